// ----- sv/dhk_pkg.sv -----
// ----------------------------------------------------------------------------
// DH kinematics package
// Shared types, fixed-point helpers and the built-in link tables of the
// forward kinematics and Jacobian unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dhk_pkg;

  localparam int JOINT_COUNT  = 6;
  localparam int CORDIC_STEPS = 16;
  localparam int NJ           = (JOINT_COUNT < 6) ? JOINT_COUNT : 6;
  localparam int JIDX_W       = (NJ > 1) ? $clog2(NJ) : 1;

  typedef logic signed [35:0] val_t;
  typedef logic signed [71:0] wide_t;
  typedef logic signed [19:0] out_t;
  typedef logic [1:0]         model_t;
  typedef logic [1:0]         alpha_t;

  localparam model_t MODEL_SMALL  = 2'd0;
  localparam model_t MODEL_LARGE  = 2'd1;
  localparam model_t MODEL_MEDIUM = 2'd2;
  localparam model_t MODEL_NONE   = 2'd3;

  localparam alpha_t ALPHA_ZERO = 2'd0;
  localparam alpha_t ALPHA_POS  = 2'd1;
  localparam alpha_t ALPHA_NEG  = 2'd2;

  localparam val_t Q30_ONE     = 36'sd1073741824;
  localparam val_t PI_Q30      = 36'sd3373259426;
  localparam val_t HALF_PI_Q30 = 36'sd1686629713;
  localparam val_t TWO_PI_Q30  = 36'sd6746518852;
  localparam val_t CORDIC_GAIN = 36'sd652032874;

  localparam wide_t HALF_Q30   = 72'sd536870912;
  localparam wide_t HALF_OUT   = 72'sd8192;
  localparam wide_t OUT_MAX_W  = 72'sd524287;
  localparam wide_t OUT_MIN_W  = -72'sd524288;

  // Item flowing through the CORDIC cells, one lane per joint.
  typedef struct {
    logic valid;
    logic mode;
    val_t x [NJ];
    val_t y [NJ];
    val_t z [NJ];
    logic flip [NJ];
  } rot_t;

  // Item flowing through the joint cells.
  typedef struct {
    logic valid;
    logic mode;
    val_t rot [3][3];
    val_t pos [3];
    val_t zax [NJ][3];
    val_t org [NJ][3];
    val_t cs  [NJ];
    val_t sn  [NJ];
  } chain_t;

  function automatic wide_t mul(val_t a, val_t b);
    return wide_t'(a) * wide_t'(b);
  endfunction

  // Round a Q60 product or sum back to Q30.
  function automatic val_t rnd30(wide_t v);
    wide_t t;
    t = (v + HALF_Q30) >>> 30;
    return t[35:0];
  endfunction

  function automatic out_t to_out(wide_t v);
    wide_t q;
    q = (v + HALF_OUT) >>> 14;
    if (q > OUT_MAX_W) begin
      q = OUT_MAX_W;
    end else if (q < OUT_MIN_W) begin
      q = OUT_MIN_W;
    end
    return q[19:0];
  endfunction

  function automatic val_t atan_q30(logic [4:0] i);
    val_t r;
    case (i)
      5'd0:    r = 36'sd843314857;
      5'd1:    r = 36'sd497837829;
      5'd2:    r = 36'sd263043837;
      5'd3:    r = 36'sd133525159;
      5'd4:    r = 36'sd67021687;
      5'd5:    r = 36'sd33543516;
      5'd6:    r = 36'sd16775851;
      5'd7:    r = 36'sd8388437;
      5'd8:    r = 36'sd4194283;
      5'd9:    r = 36'sd2097149;
      5'd10:   r = 36'sd1048576;
      5'd11:   r = 36'sd524288;
      5'd12:   r = 36'sd262144;
      5'd13:   r = 36'sd131072;
      5'd14:   r = 36'sd65536;
      5'd15:   r = 36'sd32768;
      5'd16:   r = 36'sd16384;
      5'd17:   r = 36'sd8192;
      5'd18:   r = 36'sd4096;
      5'd19:   r = 36'sd2048;
      5'd20:   r = 36'sd1024;
      5'd21:   r = 36'sd512;
      5'd22:   r = 36'sd256;
      5'd23:   r = 36'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic alpha_t sin_alpha(logic [2:0] j);
    alpha_t r;
    case (j)
      3'd0:    r = ALPHA_POS;
      3'd3:    r = ALPHA_POS;
      3'd4:    r = ALPHA_NEG;
      default: r = ALPHA_ZERO;
    endcase
    return r;
  endfunction

  // Link length a in Q30; only the shoulder and elbow links have one.
  function automatic val_t link_a(model_t m, logic [2:0] j);
    val_t r;
    r = '0;
    case (j)
      3'd1: begin
        case (m)
          MODEL_SMALL:  r = -36'sd261509821;
          MODEL_MEDIUM: r = -36'sd456340275;
          default:      r = -36'sd657881616;
        endcase
      end
      3'd2: begin
        case (m)
          MODEL_SMALL:  r = -36'sd228975444;
          MODEL_MEDIUM: r = -36'sd421121543;
          default:      r = -36'sd613750827;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Link offset d in Q30.
  function automatic val_t link_d(model_t m, logic [2:0] j);
    val_t r;
    r = '0;
    case (j)
      3'd0: begin
        case (m)
          MODEL_SMALL:  r = 36'sd163047696;
          MODEL_MEDIUM: r = 36'sd174483046;
          default:      r = 36'sd194025148;
        endcase
      end
      3'd3: begin
        case (m)
          MODEL_SMALL:  r = 36'sd140713866;
          MODEL_MEDIUM: r = 36'sd143129785;
          default:      r = 36'sd186992139;
        endcase
      end
      3'd4: begin
        case (m)
          MODEL_SMALL:  r = 36'sd91643865;
          MODEL_MEDIUM: r = 36'sd107052060;
          default:      r = 36'sd128687959;
        endcase
      end
      3'd5: begin
        case (m)
          MODEL_SMALL:  r = 36'sd98891622;
          MODEL_MEDIUM: r = 36'sd106944686;
          default:      r = 36'sd125144610;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/dhk_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode CORDIC iteration for every joint lane of a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dhk_cordic_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [4:0]          step,
  input  dhk_pkg::rot_t       d,
  output dhk_pkg::rot_t       q
);

  dhk_pkg::rot_t q_r;
  dhk_pkg::rot_t q_nxt;

  always_comb begin
    dhk_pkg::val_t dx;
    dhk_pkg::val_t dy;
    dhk_pkg::val_t at;
    q_nxt = d;
    at = dhk_pkg::atan_q30(step);
    for (int l = 0; l < dhk_pkg::NJ; l++) begin
      dx = d.y[l] >>> step;
      dy = d.x[l] >>> step;
      if (d.z[l] >= 0) begin
        q_nxt.x[l] = d.x[l] - dx;
        q_nxt.y[l] = d.y[l] + dy;
        q_nxt.z[l] = d.z[l] - at;
      end else begin
        q_nxt.x[l] = d.x[l] + dx;
        q_nxt.y[l] = d.y[l] - dy;
        q_nxt.z[l] = d.z[l] + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ----- sv/dhk_joint_cell.sv -----
// ----------------------------------------------------------------------------
// Joint cell
// Applies one DH link transform to the running rotation and position, and
// records the joint axis and origin seen before the link. Three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dhk_joint_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [2:0]          joint,
  input  dhk_pkg::model_t     model,
  input  dhk_pkg::chain_t     d,
  output dhk_pkg::chain_t     q
);

  logic [dhk_pkg::JIDX_W-1:0] jx;

  dhk_pkg::chain_t s1_r, s1_nxt;
  dhk_pkg::val_t   pa_r [3];
  dhk_pkg::val_t   pa_nxt [3];
  dhk_pkg::wide_t  p0c_r [3], p1s_r [3], p1c_r [3], p0s_r [3];
  dhk_pkg::wide_t  p0c_nxt [3], p1s_nxt [3], p1c_nxt [3], p0s_nxt [3];

  dhk_pkg::chain_t s2_r;
  dhk_pkg::val_t   rn_r [3][3];
  dhk_pkg::val_t   rn_nxt [3][3];
  dhk_pkg::wide_t  pp_r [3][3];
  dhk_pkg::wide_t  pp_nxt [3][3];

  dhk_pkg::chain_t q_r, q_nxt;

  assign jx = joint[dhk_pkg::JIDX_W-1:0];

  // Stage 1: link offsets and the rotation products with cos and sin.
  always_comb begin
    dhk_pkg::val_t ct;
    dhk_pkg::val_t st;
    dhk_pkg::val_t a;
    ct = d.cs[jx];
    st = d.sn[jx];
    a  = dhk_pkg::link_a(model, joint);
    s1_nxt = d;
    for (int r = 0; r < 3; r++) begin
      s1_nxt.zax[jx][r] = d.rot[r][2];
      s1_nxt.org[jx][r] = d.pos[r];
      p0c_nxt[r] = dhk_pkg::mul(d.rot[r][0], ct);
      p1s_nxt[r] = dhk_pkg::mul(d.rot[r][1], st);
      p1c_nxt[r] = dhk_pkg::mul(d.rot[r][1], ct);
      p0s_nxt[r] = dhk_pkg::mul(d.rot[r][0], st);
    end
    pa_nxt[0] = dhk_pkg::rnd30(dhk_pkg::mul(a, ct));
    pa_nxt[1] = dhk_pkg::rnd30(dhk_pkg::mul(a, st));
    pa_nxt[2] = dhk_pkg::link_d(model, joint);
  end

  // Stage 2: new rotation, and the old rotation applied to the link offset.
  always_comb begin
    dhk_pkg::wide_t u;
    dhk_pkg::wide_t w;
    for (int r = 0; r < 3; r++) begin
      u = p0c_r[r] + p1s_r[r];
      w = p1c_r[r] - p0s_r[r];
      rn_nxt[r][0] = dhk_pkg::rnd30(u);
      case (dhk_pkg::sin_alpha(joint))
        dhk_pkg::ALPHA_POS: begin
          rn_nxt[r][1] = s1_r.rot[r][2];
          rn_nxt[r][2] = dhk_pkg::rnd30(-w);
        end
        dhk_pkg::ALPHA_NEG: begin
          rn_nxt[r][1] = -s1_r.rot[r][2];
          rn_nxt[r][2] = dhk_pkg::rnd30(w);
        end
        default: begin
          rn_nxt[r][1] = dhk_pkg::rnd30(w);
          rn_nxt[r][2] = s1_r.rot[r][2];
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        pp_nxt[r][k] = dhk_pkg::mul(s1_r.rot[r][k], pa_r[k]);
      end
    end
  end

  // Stage 3: position update.
  always_comb begin
    q_nxt = s2_r;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        q_nxt.rot[r][k] = rn_r[r][k];
      end
      q_nxt.pos[r] = s2_r.pos[r] + dhk_pkg::rnd30(pp_r[r][0] + pp_r[r][1] + pp_r[r][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      q_r.valid  <= 1'b0;
    end else if (en) begin
      s1_r    <= s1_nxt;
      pa_r    <= pa_nxt;
      p0c_r   <= p0c_nxt;
      p1s_r   <= p1s_nxt;
      p1c_r   <= p1c_nxt;
      p0s_r   <= p0s_nxt;
      s2_r    <= s1_r;
      rn_r    <= rn_nxt;
      pp_r    <= pp_nxt;
      q_r     <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ----- sv/dhk_col_unit.sv -----
// ----------------------------------------------------------------------------
// Column unit
// Holds one finished transaction and issues its results (Jacobian columns, or
// tip only in mode 0) one per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dhk_col_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dhk_pkg::chain_t      d,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_column_index,
  output dhk_pkg::out_t        out_lin_x,
  output dhk_pkg::out_t        out_lin_y,
  output dhk_pkg::out_t        out_lin_z,
  output dhk_pkg::out_t        out_ang_x,
  output dhk_pkg::out_t        out_ang_y,
  output dhk_pkg::out_t        out_ang_z,
  output dhk_pkg::out_t        out_tip_x,
  output dhk_pkg::out_t        out_tip_y,
  output dhk_pkg::out_t        out_tip_z,
  output logic                 out_last
);

  logic                       hold_r, hold_nxt;
  logic                       mode_r;
  logic [dhk_pkg::JIDX_W-1:0] col_r, col_nxt;
  dhk_pkg::val_t              dv_r [dhk_pkg::NJ][3];
  dhk_pkg::val_t              z_r  [dhk_pkg::NJ][3];
  dhk_pkg::out_t              tip_r [3];

  logic                       ov_r, ov_nxt;
  logic [2:0]                 oc_r;
  dhk_pkg::out_t              lin_r [3];
  dhk_pkg::out_t              ang_r [3];
  dhk_pkg::out_t              otip_r [3];
  logic                       olast_r;

  logic                       issue, last_col, load;
  dhk_pkg::out_t              lin_c [3];
  dhk_pkg::out_t              ang_c [3];

  assign issue    = hold_r && (!ov_r || !out_stall);
  assign last_col = !mode_r || (col_r == dhk_pkg::JIDX_W'(dhk_pkg::NJ - 1));
  assign take     = !hold_r || (issue && last_col);
  assign load     = take && d.valid;

  always_comb begin
    dhk_pkg::val_t z [3];
    dhk_pkg::val_t v [3];
    dhk_pkg::val_t m [3][3];
    for (int r = 0; r < 3; r++) begin
      z[r] = z_r[col_r][r];
      v[r] = dv_r[col_r][r];
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        m[r][k] = dhk_pkg::rnd30(dhk_pkg::mul(z[r], v[k]));
      end
    end
    lin_c[0] = dhk_pkg::to_out(dhk_pkg::wide_t'(m[1][2]) - dhk_pkg::wide_t'(m[2][1]));
    lin_c[1] = dhk_pkg::to_out(dhk_pkg::wide_t'(m[2][0]) - dhk_pkg::wide_t'(m[0][2]));
    lin_c[2] = dhk_pkg::to_out(dhk_pkg::wide_t'(m[0][1]) - dhk_pkg::wide_t'(m[1][0]));
    for (int r = 0; r < 3; r++) begin
      ang_c[r] = dhk_pkg::to_out(dhk_pkg::wide_t'(z[r]));
      if (!mode_r) begin
        lin_c[r] = '0;
        ang_c[r] = '0;
      end
    end
  end

  always_comb begin
    hold_nxt = hold_r;
    col_nxt  = col_r;
    if (load) begin
      hold_nxt = 1'b1;
      col_nxt  = '0;
    end else if (issue && last_col) begin
      hold_nxt = 1'b0;
    end else if (issue) begin
      col_nxt = col_r + 1'b1;
    end
    ov_nxt = issue || (ov_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      ov_r   <= 1'b0;
      col_r  <= '0;
    end else begin
      hold_r <= hold_nxt;
      ov_r   <= ov_nxt;
      col_r  <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mode_r <= d.mode;
      for (int i = 0; i < dhk_pkg::NJ; i++) begin
        for (int r = 0; r < 3; r++) begin
          dv_r[i][r] <= d.pos[r] - d.org[i][r];
          z_r[i][r]  <= d.zax[i][r];
        end
      end
      for (int r = 0; r < 3; r++) begin
        tip_r[r] <= dhk_pkg::to_out(dhk_pkg::wide_t'(d.pos[r]));
      end
    end
    if (issue) begin
      oc_r    <= 3'(col_r);
      lin_r   <= lin_c;
      ang_r   <= ang_c;
      otip_r  <= tip_r;
      olast_r <= last_col;
    end
  end

  assign out_valid        = ov_r;
  assign out_column_index = oc_r;
  assign out_lin_x        = lin_r[0];
  assign out_lin_y        = lin_r[1];
  assign out_lin_z        = lin_r[2];
  assign out_ang_x        = ang_r[0];
  assign out_ang_y        = ang_r[1];
  assign out_ang_z        = ang_r[2];
  assign out_tip_x        = otip_r[0];
  assign out_tip_y        = otip_r[1];
  assign out_tip_z        = otip_r[2];
  assign out_last         = olast_r;

endmodule

`default_nettype wire

// ----- sv/dh_kinematics_jacobian_unit.sv -----
// ----------------------------------------------------------------------------
// DH kinematics and Jacobian unit
// Forward kinematics of a six-joint arm from one of three built-in DH tables,
// with the tool-tip position or the full geometric Jacobian as results.
// ----------------------------------------------------------------------------
//  channel | ports                                     | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, in_mode, in_joint_*   | input
//  out     | out_valid, out_stall, out_column_index, . | output
//  cfg     | cfg_we, cfg_wdata (robot model, 2 bits)   | input
//
// A new transaction can enter every cycle while in_stall is low; the column
// unit issues one result per cycle unless stalled, NJ for mode 1, one for mode 0.
// Each transaction passes the input register, the CORDIC cells and the joint cells.
// Reset (synchronous, rst_n low) empties the pipeline and selects the large arm.
// When the column unit cannot take the valid item at the end of the joint cells,
// the whole cell chain holds and in_stall is raised.
`default_nettype none

module dh_kinematics_jacobian_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic signed [15:0]   in_joint_angle_0,
  input  logic signed [15:0]   in_joint_angle_1,
  input  logic signed [15:0]   in_joint_angle_2,
  input  logic signed [15:0]   in_joint_angle_3,
  input  logic signed [15:0]   in_joint_angle_4,
  input  logic signed [15:0]   in_joint_angle_5,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_column_index,
  output logic signed [19:0]   out_lin_x,
  output logic signed [19:0]   out_lin_y,
  output logic signed [19:0]   out_lin_z,
  output logic signed [19:0]   out_ang_x,
  output logic signed [19:0]   out_ang_y,
  output logic signed [19:0]   out_ang_z,
  output logic signed [19:0]   out_tip_x,
  output logic signed [19:0]   out_tip_y,
  output logic signed [19:0]   out_tip_z,
  output logic                 out_last
);

  dhk_pkg::model_t  robot_model_r;
  logic             en, take;
  logic signed [15:0] ang [6];

  dhk_pkg::rot_t    c0_r, c0_nxt;
  dhk_pkg::rot_t    cst [dhk_pkg::CORDIC_STEPS+1];
  dhk_pkg::chain_t  ch0_r, ch0_nxt;
  dhk_pkg::chain_t  jch [dhk_pkg::NJ+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      robot_model_r <= dhk_pkg::MODEL_LARGE;
    end else if (cfg_we && cfg_wdata != dhk_pkg::MODEL_NONE) begin
      robot_model_r <= cfg_wdata;
    end
  end

  assign ang[0] = in_joint_angle_0;
  assign ang[1] = in_joint_angle_1;
  assign ang[2] = in_joint_angle_2;
  assign ang[3] = in_joint_angle_3;
  assign ang[4] = in_joint_angle_4;
  assign ang[5] = in_joint_angle_5;

  assign en       = !jch[dhk_pkg::NJ].valid || take;
  assign in_stall = !en;

  // Bring each angle into [-pi, pi], then fold it into [-pi/2, pi/2].
  always_comb begin
    dhk_pkg::val_t t;
    c0_nxt.valid = in_valid;
    c0_nxt.mode  = in_mode;
    for (int l = 0; l < dhk_pkg::NJ; l++) begin
      t = {{2{ang[l][15]}}, ang[l], 18'b0};
      if (t > dhk_pkg::PI_Q30) begin
        t = t - dhk_pkg::TWO_PI_Q30;
      end else if (t < -dhk_pkg::PI_Q30) begin
        t = t + dhk_pkg::TWO_PI_Q30;
      end
      c0_nxt.flip[l] = 1'b0;
      if (t > dhk_pkg::HALF_PI_Q30) begin
        t = t - dhk_pkg::PI_Q30;
        c0_nxt.flip[l] = 1'b1;
      end else if (t < -dhk_pkg::HALF_PI_Q30) begin
        t = t + dhk_pkg::PI_Q30;
        c0_nxt.flip[l] = 1'b1;
      end
      c0_nxt.x[l] = dhk_pkg::CORDIC_GAIN;
      c0_nxt.y[l] = '0;
      c0_nxt.z[l] = t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r.valid  <= 1'b0;
      ch0_r.valid <= 1'b0;
    end else if (en) begin
      c0_r  <= c0_nxt;
      ch0_r <= ch0_nxt;
    end
  end

  assign cst[0] = c0_r;

  for (genvar k = 0; k < dhk_pkg::CORDIC_STEPS; k++) begin : g_cordic
    dhk_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .step  (5'(k)),
      .d     (cst[k]),
      .q     (cst[k+1])
    );
  end

  // Start the chain from the base frame with the signed sine and cosine.
  always_comb begin
    ch0_nxt.valid = cst[dhk_pkg::CORDIC_STEPS].valid;
    ch0_nxt.mode  = cst[dhk_pkg::CORDIC_STEPS].mode;
    for (int r = 0; r < 3; r++) begin
      ch0_nxt.pos[r] = '0;
      for (int k = 0; k < 3; k++) begin
        ch0_nxt.rot[r][k] = (r == k) ? dhk_pkg::Q30_ONE : '0;
      end
    end
    for (int l = 0; l < dhk_pkg::NJ; l++) begin
      for (int r = 0; r < 3; r++) begin
        ch0_nxt.zax[l][r] = '0;
        ch0_nxt.org[l][r] = '0;
      end
      if (cst[dhk_pkg::CORDIC_STEPS].flip[l]) begin
        ch0_nxt.cs[l] = -cst[dhk_pkg::CORDIC_STEPS].x[l];
        ch0_nxt.sn[l] = -cst[dhk_pkg::CORDIC_STEPS].y[l];
      end else begin
        ch0_nxt.cs[l] = cst[dhk_pkg::CORDIC_STEPS].x[l];
        ch0_nxt.sn[l] = cst[dhk_pkg::CORDIC_STEPS].y[l];
      end
    end
  end

  assign jch[0] = ch0_r;

  for (genvar j = 0; j < dhk_pkg::NJ; j++) begin : g_joint
    dhk_joint_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .joint (3'(j)),
      .model (robot_model_r),
      .d     (jch[j]),
      .q     (jch[j+1])
    );
  end

  dhk_col_unit u_col (
    .clk              (clk),
    .rst_n            (rst_n),
    .d                (jch[dhk_pkg::NJ]),
    .take             (take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_index (out_column_index),
    .out_lin_x        (out_lin_x),
    .out_lin_y        (out_lin_y),
    .out_lin_z        (out_lin_z),
    .out_ang_x        (out_ang_x),
    .out_ang_y        (out_ang_y),
    .out_ang_z        (out_ang_z),
    .out_tip_x        (out_tip_x),
    .out_tip_y        (out_tip_y),
    .out_tip_z        (out_tip_z),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// ----- test/dh_kinematics_jacobian_unit_tb.sv -----
// ----------------------------------------------------------------------------
// DH kinematics and Jacobian unit testbench
// Drives joint-angle transactions in both modes across all arm models, predicts
// tool-tip positions and Jacobian columns in fixed point, and checks each
// result in order while both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module dh_kinematics_jacobian_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = dhk_pkg::CORDIC_STEPS + 3 * dhk_pkg::NJ + 40;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef struct {
    logic [2:0]         col;
    logic signed [19:0] lin [3];
    logic signed [19:0] ang [3];
    logic signed [19:0] tip [3];
    logic               last;
  } column_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic signed [15:0] in_ja [6] = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_column_index;
  logic signed [19:0] out_lin_x, out_lin_y, out_lin_z;
  logic signed [19:0] out_ang_x, out_ang_y, out_ang_z;
  logic signed [19:0] out_tip_x, out_tip_y, out_tip_z;
  logic out_last;

  dhk_pkg::model_t arm_model = dhk_pkg::MODEL_LARGE;
  column_t pending_columns [$];
  int mismatches = 0;
  int items_sent = 0;
  int columns_seen = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  dh_kinematics_jacobian_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_joint_angle_0(in_ja[0]), .in_joint_angle_1(in_ja[1]),
    .in_joint_angle_2(in_ja[2]), .in_joint_angle_3(in_ja[3]),
    .in_joint_angle_4(in_ja[4]), .in_joint_angle_5(in_ja[5]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_column_index(out_column_index),
    .out_lin_x(out_lin_x), .out_lin_y(out_lin_y), .out_lin_z(out_lin_z),
    .out_ang_x(out_ang_x), .out_ang_y(out_ang_y), .out_ang_z(out_ang_z),
    .out_tip_x(out_tip_x), .out_tip_y(out_tip_y), .out_tip_z(out_tip_z),
    .out_last(out_last)
  );

  // Fixed-point arithmetic, all in 64-bit signed integers.
  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint mul_round(longint a, longint b);
    return shr_floor(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic logic signed [19:0] q316(longint v);
    longint q;
    q = shr_floor(v + 8192, 14);
    if (q > 524287) q = 524287;
    if (q < -524288) q = -524288;
    return q[19:0];
  endfunction

  function automatic longint arctan_q30(int i);
    longint t [24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    return t[i];
  endfunction

  task automatic cordic_sincos(input logic signed [15:0] ang, output longint c,
                               output longint s);
    longint t, x, y, dx, dy;
    bit flip;
    t = longint'(ang) * 262144;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    while (t > PI_Q30) t -= TWO_PI_Q30;
    while (t < -PI_Q30) t += TWO_PI_Q30;
    // Fold into the CORDIC convergence range; both outputs change sign.
    if (t > HALF_PI_Q30) begin
      t -= PI_Q30;
      flip = 1'b1;
    end else if (t < -HALF_PI_Q30) begin
      t += PI_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < dhk_pkg::CORDIC_STEPS && i < 24; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (t >= 0) begin
        x -= dx; y += dy; t -= arctan_q30(i);
      end else begin
        x += dx; y -= dy; t += arctan_q30(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint arm_a(dhk_pkg::model_t m, int j);
    longint t [3][6] = '{'{0, -261509821, -228975444, 0, 0, 0},
                         '{0, -657881616, -613750827, 0, 0, 0},
                         '{0, -456340275, -421121543, 0, 0, 0}};
    return t[m][j];
  endfunction

  function automatic longint arm_d(dhk_pkg::model_t m, int j);
    longint t [3][6] = '{'{163047696, 0, 0, 140713866, 91643865, 98891622},
                         '{194025148, 0, 0, 186992139, 128687959, 125144610},
                         '{174483046, 0, 0, 143129785, 107052060, 106944686}};
    return t[m][j];
  endfunction

  task automatic predict_kinematics(input logic mode, input logic signed [15:0] ja [6]);
    longint rot [3][3], pos [3], axis [6][3], origin [6][3];
    longint rn [3][3], pn [3], a [3][3], pa [3], ct, st, sa, ca, acc, a2;
    longint dv [3];
    column_t c;
    rot = '{'{1073741824, 0, 0}, '{0, 1073741824, 0}, '{0, 0, 1073741824}};
    pos = '{0, 0, 0};
    for (int i = 0; i < dhk_pkg::NJ; i++) begin
      sa = (i == 0 || i == 3) ? 1 : (i == 4) ? -1 : 0;
      ca = (sa == 0) ? 1 : 0;
      for (int r = 0; r < 3; r++) begin
        axis[i][r] = rot[r][2];
        origin[i][r] = pos[r];
      end
      cordic_sincos(ja[i], ct, st);
      a = '{'{ct, -st * ca, st * sa}, '{st, ct * ca, -ct * sa},
            '{0, sa * 1073741824, ca * 1073741824}};
      pa[0] = mul_round(arm_a(arm_model, i), ct);
      pa[1] = mul_round(arm_a(arm_model, i), st);
      pa[2] = arm_d(arm_model, i);
      for (int r = 0; r < 3; r++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) begin
          a2 = 0;
          for (int j = 0; j < 3; j++) a2 += rot[r][j] * a[j][k];
          rn[r][k] = shr_floor(a2 + (64'sd1 <<< 29), 30);
          acc += rot[r][k] * pa[k];
        end
        pn[r] = pos[r] + shr_floor(acc + (64'sd1 <<< 29), 30);
      end
      rot = rn;
      pos = pn;
    end
    for (int r = 0; r < 3; r++) c.tip[r] = q316(pos[r]);
    if (!mode) begin
      c.col = '0;
      for (int r = 0; r < 3; r++) begin
        c.lin[r] = '0;
        c.ang[r] = '0;
      end
      c.last = 1'b1;
      pending_columns.push_back(c);
    end else begin
      for (int i = 0; i < dhk_pkg::NJ; i++) begin
        for (int r = 0; r < 3; r++) dv[r] = pos[r] - origin[i][r];
        c.col = 3'(i);
        c.lin[0] = q316(mul_round(axis[i][1], dv[2]) - mul_round(axis[i][2], dv[1]));
        c.lin[1] = q316(mul_round(axis[i][2], dv[0]) - mul_round(axis[i][0], dv[2]));
        c.lin[2] = q316(mul_round(axis[i][0], dv[1]) - mul_round(axis[i][1], dv[0]));
        for (int r = 0; r < 3; r++) c.ang[r] = q316(axis[i][r]);
        c.last = (i == dhk_pkg::NJ - 1);
        pending_columns.push_back(c);
      end
    end
  endtask

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 15);
  endfunction

  // Result checker and output stall generator.
  always @(posedge clk) begin
    column_t e;
    logic signed [19:0] got [9];
    logic signed [19:0] exp_v [9];
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        columns_seen++;
        got = '{out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z,
                out_tip_x, out_tip_y, out_tip_z};
        if (pending_columns.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result column %0d", out_column_index);
        end else begin
          e = pending_columns.pop_front();
          exp_v = '{e.lin[0], e.lin[1], e.lin[2], e.ang[0], e.ang[1], e.ang[2],
                    e.tip[0], e.tip[1], e.tip[2]};
          if (got != exp_v || out_column_index != e.col || out_last != e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch col exp %0d got %0d, last exp %0b got %0b",
                       e.col, out_column_index, e.last, out_last);
              $display("  expected lin/ang/tip %p", exp_v);
              $display("  actual   lin/ang/tip %p", got);
            end
          end
        end
      end
      out_stall <= idle_now();
    end
  end

  // Watchdog: cycles with no accepted transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending_columns.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Valid stays high between back-to-back transactions; it drops only while
  // idling or draining.
  task automatic send_item(input logic mode, input logic signed [15:0] ja [6]);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    for (int j = 0; j < 6; j++) in_ja[j] <= ja[j];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_kinematics(mode, ja);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_model(input logic [1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (value != dhk_pkg::MODEL_NONE) arm_model = value;
  endtask

  task automatic random_angles(output logic signed [15:0] ja [6]);
    for (int j = 0; j < 6; j++) begin
      case ($urandom_range(3))
        0: ja[j] = 16'($urandom);
        1: ja[j] = 16'($signed($urandom_range(25736)) - 12868);
        2: ja[j] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        default: ja[j] = 16'($signed($urandom_range(12868)) - 6434);
      endcase
    end
  endtask

  task automatic test_directed_extremes();
    logic signed [15:0] ja [6];
    logic signed [15:0] picks [8] = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh1922,
      -16'sh1922, 16'sh3244, -16'sh3244, 16'shffff};
    for (int p = 0; p < 8; p++) begin
      for (int j = 0; j < 6; j++) ja[j] = picks[p];
      send_item(p[0], ja);
    end
    for (int j = 0; j < 6; j++) ja[j] = 16'sh5555 ^ {16{j[0]}};
    send_item(1'b1, ja);
    send_item(1'b0, ja);
  endtask

  task automatic test_models();
    logic signed [15:0] ja [6];
    logic [1:0] order [5] = '{dhk_pkg::MODEL_SMALL, dhk_pkg::MODEL_NONE,
                              dhk_pkg::MODEL_MEDIUM, dhk_pkg::MODEL_LARGE,
                              dhk_pkg::MODEL_SMALL};
    for (int m = 0; m < 5; m++) begin
      write_model(order[m]);
      for (int k = 0; k < 3; k++) begin
        random_angles(ja);
        send_item(k[0], ja);
      end
    end
  endtask

  task automatic test_random(input int count);
    logic signed [15:0] ja [6];
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) write_model(2'($urandom_range(2)));
      quiet = (n >= count / 2) && (n < count / 2 + 50);
      random_angles(ja);
      send_item(1'($urandom_range(1)), ja);
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_models();
    test_random(345);
    drain_results();
    $display("Sent %0d transactions over all arm models, checked %0d result columns.",
             items_sent, columns_seen);
    if (mismatches == 0 && pending_columns.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_columns.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
